FILE: rtl/core/bsre_pkg.sv
`timescale 1ns / 1ps

package bsre_pkg;

	localparam logic [23:0] HALT_CODE = 24'h123456;
	localparam logic [23:0] IMM24_MASK = 24'hFFFFFF;
	localparam logic [1:0] MSR_SELECT = 2'b10;
	localparam logic [31:0] CPSR_RESET = 32'h0000_00D3;
	localparam logic [31:0] SPSR_RESET = 32'h0000_0000;
	localparam logic [31:0] LINK_ADJUST = 32'd4;

	typedef enum logic [1:0] {
		OP_BRANCH = 2'd0,
		OP_SWI = 2'd1,
		OP_PSR = 2'd2,
		OP_RSVD = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_SWI = 2'd1,
		ST_UNDEF = 2'd2,
		ST_HALT = 2'd3
	} status_t;

	typedef struct packed {
		op_t operation;
		logic [31:0] instruction;
		logic [31:0] pc_value;
		logic [31:0] rm_value;
	} in_item_t;

	typedef struct packed {
		logic link_write;
		logic [31:0] link_data;
		logic dest_write;
		logic [3:0] dest_index;
		logic [31:0] dest_data;
		logic pc_write;
		logic [31:0] pc_next;
		status_t status;
	} out_item_t;

	typedef struct packed {
		logic en;
		logic saved;
		logic [31:0] value;
	} psr_wr_t;

endpackage

FILE: rtl/core/bsre_in_if.sv
`timescale 1ns / 1ps

interface bsre_in_if;
	import bsre_pkg::*;

	logic valid;
	logic ready;
	in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/core/bsre_out_if.sv
`timescale 1ns / 1ps

interface bsre_out_if;
	import bsre_pkg::*;

	logic valid;
	logic ready;
	out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/core/branch_swi_status_register_execute.sv
`timescale 1ns / 1ps

// Channel  Modport  Payload     Role
// cmd      sink     in_item_t   Classified instruction with pc and rm values.
// res      source   out_item_t  Register writes, branch target and status code.
//
// Each transaction passes through the input register and then the result
// register, and one transaction can be accepted in every cycle while res does
// not stall. The status words change only when an MSR transaction moves from
// the input register to the result register. Reset sets the current status
// word to 0xD3 and the saved one to zero. A stall on res holds the result register
// and then the input register, and cmd ready falls only when both are full.

module branch_swi_status_register_execute (
	input logic clk,
	input logic arst_n,
	bsre_in_if.sink cmd,
	bsre_out_if.source res
);
	import bsre_pkg::*;

	logic valid_s1;
	in_item_t item_s1;
	logic valid_s2;
	out_item_t result_s2;
	logic advance;
	out_item_t result;
	psr_wr_t psr_wr;
	logic [31:0] cpsr;
	logic [31:0] spsr;

	assign advance = valid_s1 && (!valid_s2 || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1 <= cmd.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	bsre_exec u_exec (
		.item(item_s1),
		.fire(advance),
		.cpsr(cpsr),
		.spsr(spsr),
		.result(result),
		.psr_wr(psr_wr)
	);

	bsre_psr u_psr (
		.clk(clk),
		.arst_n(arst_n),
		.wr(psr_wr),
		.cpsr(cpsr),
		.spsr(spsr)
	);

	assign res.valid = valid_s2;
	assign res.data = result_s2;

`ifndef SYNTH
	a_link_is_branch: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.link_write |-> result_s2.pc_write)
		else $error("link write without a branch");

	a_branch_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.pc_write |-> !result_s2.dest_write && result_s2.status == ST_DONE)
		else $error("branch result carries a register copy or a fault");

	a_dest_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result_s2.dest_write |-> result_s2.dest_index == 4'd0)
		else $error("destination index set without a register write");

	a_psr_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		psr_wr.en |-> advance && item_s1.operation == OP_PSR)
		else $error("status word written outside an advancing MSR");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a stalled transaction");
`endif

endmodule

FILE: rtl/core/bsre_psr.sv
`timescale 1ns / 1ps

module bsre_psr (
	input logic clk,
	input logic arst_n,
	input bsre_pkg::psr_wr_t wr,
	output logic [31:0] cpsr,
	output logic [31:0] spsr
);
	import bsre_pkg::*;

	logic [31:0] cpsr_q;
	logic [31:0] spsr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpsr_q <= CPSR_RESET;
			spsr_q <= SPSR_RESET;
		end else if (wr.en) begin
			if (wr.saved) begin
				spsr_q <= wr.value;
			end else begin
				cpsr_q <= wr.value;
			end
		end
	end

	assign cpsr = cpsr_q;
	assign spsr = spsr_q;

endmodule

FILE: rtl/core/bsre_exec.sv
`timescale 1ns / 1ps

module bsre_exec (
	input bsre_pkg::in_item_t item,
	input logic fire,
	input logic [31:0] cpsr,
	input logic [31:0] spsr,
	output bsre_pkg::out_item_t result,
	output bsre_pkg::psr_wr_t psr_wr
);
	import bsre_pkg::*;

	logic [31:0] ins;
	logic [31:0] offset;
	logic [4:0] rot_amt;
	logic [63:0] imm_pair;
	logic [63:0] imm_shift;
	logic [31:0] operand;
	logic [31:0] old_psr;
	logic [31:0] byte_sel;
	logic use_saved;
	logic is_msr;

	assign ins = item.instruction;
	assign offset = {{6{ins[23]}}, ins[23:0], 2'b00};
	assign rot_amt = {ins[11:8], 1'b0};
	assign imm_pair = {24'd0, ins[7:0], 24'd0, ins[7:0]};
	assign imm_shift = imm_pair >> rot_amt;
	assign operand = ins[25] ? imm_shift[31:0] : item.rm_value;
	assign use_saved = ins[22];
	assign is_msr = (ins[21:20] == MSR_SELECT);
	assign old_psr = use_saved ? spsr : cpsr;
	assign byte_sel = {{8{ins[19]}}, {8{ins[18]}}, {8{ins[17]}}, {8{ins[16]}}};

	always_comb begin
		result = '0;
		result.status = ST_DONE;
		psr_wr.en = 1'b0;
		psr_wr.saved = use_saved;
		psr_wr.value = (old_psr & ~byte_sel) | (operand & byte_sel);
		unique case (item.operation)
			OP_BRANCH: begin
				result.pc_write = 1'b1;
				result.pc_next = item.pc_value + offset;
				if (ins[24]) begin
					result.link_write = 1'b1;
					result.link_data = item.pc_value - LINK_ADJUST;
				end
			end
			OP_SWI: begin
				if (!ins[24]) begin
					result.status = ST_UNDEF;
				end else if ((ins[23:0] & IMM24_MASK) == HALT_CODE) begin
					result.status = ST_HALT;
				end else begin
					result.status = ST_SWI;
				end
			end
			OP_PSR: begin
				if (is_msr) begin
					psr_wr.en = fire;
				end else begin
					result.dest_write = 1'b1;
					result.dest_index = ins[15:12];
					result.dest_data = old_psr;
				end
			end
			OP_RSVD: begin
				result.status = ST_UNDEF;
			end
		endcase
	end

endmodule
